### design/retry_handshake_timeout_controller_unit_macros.svh
// Assertion macros for the retry handshake timeout controller.
`ifndef RETRY_HANDSHAKE_TIMEOUT_CONTROLLER_UNIT_MACROS_SVH
`define RETRY_HANDSHAKE_TIMEOUT_CONTROLLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define RHTC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define RHTC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define RHTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RHTC_ASSERT_ALWAYS(label, cond, msg)
`define RHTC_ASSERT_IMPLIES(label, ante, cons, msg)
`define RHTC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### design/rhtc_pkg.sv
// Shared types and constants for the retry handshake timeout controller.
package rhtc_pkg;

   localparam int TimeWidth   = 32;
   localparam int CfgWidth    = 16;
   localparam int CountWidth  = 16;
   localparam int ModeWidth   = 3;
   localparam int CsrIdxWidth = 3;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_BEGIN  = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_TAKE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_BEGUN     = 3'd1,
      EV_REJECTED  = 3'd2,
      EV_SUCCESS   = 3'd3,
      EV_INVALID   = 3'd4,
      EV_TIMEOUT   = 3'd5,
      EV_CANCELLED = 3'd6
   } event_type;

   localparam logic [CsrIdxWidth-1:0] CSR_INITIAL_DELAY  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RETRY_DELAY    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_REFRESH_IVL    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_HARD_RESET_IVL = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_DEFAULT_TO     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_MODE_ONE_TO    = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_MODE_FIVE_TO   = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_QUIET_WINDOW   = 3'd7;

   localparam logic [CfgWidth-1:0] RST_INITIAL_DELAY  = 16'd90;
   localparam logic [CfgWidth-1:0] RST_RETRY_DELAY    = 16'd180;
   localparam logic [CfgWidth-1:0] RST_REFRESH_IVL    = 16'd350;
   localparam logic [CfgWidth-1:0] RST_HARD_RESET_IVL = 16'd650;
   localparam logic [CfgWidth-1:0] RST_DEFAULT_TO     = 16'd1500;
   localparam logic [CfgWidth-1:0] RST_MODE_ONE_TO    = 16'd4000;
   localparam logic [CfgWidth-1:0] RST_MODE_FIVE_TO   = 16'd2500;
   localparam logic [CfgWidth-1:0] RST_QUIET_WINDOW   = 16'd900;

   localparam logic [ModeWidth-1:0] MODE_ONE  = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_FIVE = 3'd5;

   typedef struct packed {
      kind_type             kind;
      logic [TimeWidth-1:0] now_ms;
      logic                 session_open;
      logic                 target_valid;
      logic [ModeWidth-1:0] begin_mode;
      logic                 attempt_accepted;
   } req_type;

   typedef struct packed {
      event_type             event_res;
      logic                  do_hard_reset;
      logic                  do_refresh;
      logic                  do_attempt;
      logic                  busy_res;
      logic [ModeWidth-1:0]  mode_now;
      logic                  open_flag;
      logic                  success_read;
      logic [CountWidth-1:0] attempt_count;
   } rsp_type;

   typedef struct packed {
      logic [CfgWidth-1:0] initial_delay_ms;
      logic [CfgWidth-1:0] retry_delay_ms;
      logic [CfgWidth-1:0] refresh_interval_ms;
      logic [CfgWidth-1:0] hard_reset_interval_ms;
      logic [CfgWidth-1:0] default_timeout_ms;
      logic [CfgWidth-1:0] mode_one_timeout_ms;
      logic [CfgWidth-1:0] mode_five_timeout_ms;
      logic [CfgWidth-1:0] quiet_window_ms;
   } cfg_type;

   function automatic logic [TimeWidth-1:0] add_ms(input logic [TimeWidth-1:0] t,
                                                   input logic [CfgWidth-1:0] span);
      return t + {{(TimeWidth-CfgWidth){1'b0}}, span};
   endfunction

   function automatic logic reached(input logic [TimeWidth-1:0] now,
                                    input logic [TimeWidth-1:0] t);
      logic [TimeWidth-1:0] d;
      d = now - t;
      return ~d[TimeWidth-1];
   endfunction

   function automatic logic elapsed(input logic [TimeWidth-1:0] now,
                                    input logic [TimeWidth-1:0] since,
                                    input logic [CfgWidth-1:0] span);
      logic [TimeWidth-1:0] d;
      d = now - since;
      return ~d[TimeWidth-1] && (d >= {{(TimeWidth-CfgWidth){1'b0}}, span});
   endfunction

endpackage

### design/rhtc_cfg.sv
// Configuration register file of the retry handshake timeout controller.
module rhtc_cfg
   import rhtc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_DELAY:  cfg_in.initial_delay_ms       = csr_wdata;
            CSR_RETRY_DELAY:    cfg_in.retry_delay_ms         = csr_wdata;
            CSR_REFRESH_IVL:    cfg_in.refresh_interval_ms    = csr_wdata;
            CSR_HARD_RESET_IVL: cfg_in.hard_reset_interval_ms = csr_wdata;
            CSR_DEFAULT_TO:     cfg_in.default_timeout_ms     = csr_wdata;
            CSR_MODE_ONE_TO:    cfg_in.mode_one_timeout_ms    = csr_wdata;
            CSR_MODE_FIVE_TO:   cfg_in.mode_five_timeout_ms   = csr_wdata;
            CSR_QUIET_WINDOW:   cfg_in.quiet_window_ms        = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_delay_ms       <= RST_INITIAL_DELAY;
         cfg_ff.retry_delay_ms         <= RST_RETRY_DELAY;
         cfg_ff.refresh_interval_ms    <= RST_REFRESH_IVL;
         cfg_ff.hard_reset_interval_ms <= RST_HARD_RESET_IVL;
         cfg_ff.default_timeout_ms     <= RST_DEFAULT_TO;
         cfg_ff.mode_one_timeout_ms    <= RST_MODE_ONE_TO;
         cfg_ff.mode_five_timeout_ms   <= RST_MODE_FIVE_TO;
         cfg_ff.quiet_window_ms        <= RST_QUIET_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/rhtc_core.sv
// Session state and per-item update logic of the retry handshake timeout controller.
module rhtc_core
   import rhtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic                  active_ff, active_in;
   logic [ModeWidth-1:0]  mode_ff, mode_in;
   logic                  succeeded_ff, succeeded_in;
   logic                  issued_ff, issued_in;
   logic [CountWidth-1:0] attempts_ff, attempts_in;
   logic [TimeWidth-1:0]  deadline_ff, deadline_in;
   logic [TimeWidth-1:0]  next_attempt_ff, next_attempt_in;
   logic [TimeWidth-1:0]  quiet_until_ff, quiet_until_in;
   logic                  quiet_set_ff, quiet_set_in;
   logic [TimeWidth-1:0]  last_hard_ff, last_hard_in;
   logic                  hard_set_ff, hard_set_in;
   logic [TimeWidth-1:0]  last_refresh_ff, last_refresh_in;
   logic                  refresh_set_ff, refresh_set_in;

   event_type             evt;
   logic                  hard, refresh, attempt, sread, issued_now;
   logic [CfgWidth-1:0]   timeout;
   logic [TimeWidth-1:0]  now;

   assign now = item.now_ms;

   always_comb begin
      active_in       = active_ff;
      mode_in         = mode_ff;
      succeeded_in    = succeeded_ff;
      issued_in       = issued_ff;
      attempts_in     = attempts_ff;
      deadline_in     = deadline_ff;
      next_attempt_in = next_attempt_ff;
      quiet_until_in  = quiet_until_ff;
      quiet_set_in    = quiet_set_ff;
      last_hard_in    = last_hard_ff;
      hard_set_in     = hard_set_ff;
      last_refresh_in = last_refresh_ff;
      refresh_set_in  = refresh_set_ff;
      evt             = EV_NONE;
      hard            = 1'b0;
      refresh         = 1'b0;
      attempt         = 1'b0;
      sread           = 1'b0;
      issued_now      = issued_ff | item.attempt_accepted;

      if (item.begin_mode == MODE_ONE) begin
         timeout = cfg.mode_one_timeout_ms;
      end else if (item.begin_mode == MODE_FIVE) begin
         timeout = cfg.mode_five_timeout_ms;
      end else begin
         timeout = cfg.default_timeout_ms;
      end

      // drop the whole session on begin, cancel, invalid target and timeout
      if (item.kind == KIND_BEGIN || item.kind == KIND_CANCEL ||
          (item.kind == KIND_TICK && active_ff && !item.session_open &&
           (!item.target_valid || reached(now, deadline_ff)))) begin
         active_in       = 1'b0;
         mode_in         = '0;
         succeeded_in    = 1'b0;
         issued_in       = 1'b0;
         attempts_in     = '0;
         deadline_in     = '0;
         next_attempt_in = '0;
         quiet_until_in  = '0;
         quiet_set_in    = 1'b0;
         last_hard_in    = '0;
         hard_set_in     = 1'b0;
         last_refresh_in = '0;
         refresh_set_in  = 1'b0;
      end

      case (item.kind)
         KIND_BEGIN: begin
            if (!item.target_valid) begin
               evt = EV_REJECTED;
            end else begin
               active_in       = 1'b1;
               mode_in         = item.begin_mode;
               next_attempt_in = add_ms(now, cfg.initial_delay_ms);
               deadline_in     = add_ms(now, timeout);
               evt             = EV_BEGUN;
            end
         end
         KIND_CANCEL: begin
            evt = EV_CANCELLED;
         end
         KIND_TAKE: begin
            sread        = succeeded_ff;
            succeeded_in = 1'b0;
         end
         KIND_TICK: begin
            if (active_ff) begin
               if (item.session_open) begin
                  succeeded_in = 1'b1;
                  active_in    = 1'b0;
                  mode_in      = '0;
                  evt          = EV_SUCCESS;
               end else if (!item.target_valid) begin
                  evt = EV_INVALID;
               end else if (reached(now, deadline_ff)) begin
                  evt = EV_TIMEOUT;
               end else if (!(issued_ff && quiet_set_ff && !reached(now, quiet_until_ff))) begin
                  if (!issued_ff && (!hard_set_ff || attempts_ff == '0 ||
                      elapsed(now, last_hard_ff, cfg.hard_reset_interval_ms))) begin
                     hard         = 1'b1;
                     last_hard_in = now;
                     hard_set_in  = 1'b1;
                  end else if (!issued_ff && (!refresh_set_ff ||
                      elapsed(now, last_refresh_ff, cfg.refresh_interval_ms))) begin
                     refresh         = 1'b1;
                     last_refresh_in = now;
                     refresh_set_in  = 1'b1;
                  end
                  if (reached(now, next_attempt_ff)) begin
                     attempt   = 1'b1;
                     issued_in = issued_now;
                     if (attempts_ff != '1) begin
                        attempts_in = attempts_ff + 1'b1;
                     end
                     if (issued_now) begin
                        quiet_until_in  = add_ms(now, cfg.quiet_window_ms);
                        quiet_set_in    = 1'b1;
                        next_attempt_in = add_ms(now, cfg.quiet_window_ms);
                     end else begin
                        next_attempt_in = add_ms(now, cfg.retry_delay_ms);
                     end
                  end
               end
            end
         end
         default: begin
            evt = EV_NONE;
         end
      endcase

      result.event_res     = evt;
      result.do_hard_reset = hard;
      result.do_refresh    = refresh;
      result.do_attempt    = attempt;
      result.busy_res      = active_in;
      result.mode_now      = active_in ? mode_in : '0;
      result.open_flag     = active_in | item.session_open;
      result.success_read  = sread;
      result.attempt_count = attempts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         mode_ff         <= '0;
         succeeded_ff    <= 1'b0;
         issued_ff       <= 1'b0;
         attempts_ff     <= '0;
         deadline_ff     <= '0;
         next_attempt_ff <= '0;
         quiet_until_ff  <= '0;
         quiet_set_ff    <= 1'b0;
         last_hard_ff    <= '0;
         hard_set_ff     <= 1'b0;
         last_refresh_ff <= '0;
         refresh_set_ff  <= 1'b0;
      end else if (step) begin
         active_ff       <= active_in;
         mode_ff         <= mode_in;
         succeeded_ff    <= succeeded_in;
         issued_ff       <= issued_in;
         attempts_ff     <= attempts_in;
         deadline_ff     <= deadline_in;
         next_attempt_ff <= next_attempt_in;
         quiet_until_ff  <= quiet_until_in;
         quiet_set_ff    <= quiet_set_in;
         last_hard_ff    <= last_hard_in;
         hard_set_ff     <= hard_set_in;
         last_refresh_ff <= last_refresh_in;
         refresh_set_ff  <= refresh_set_in;
      end
   end

endmodule

### design/retry_handshake_timeout_controller_unit.sv
// Top level of the retry handshake timeout controller.
//
//   channel   direction  ports                              transfer when
//   req       in         req_valid req_ready req_data       req_valid && req_ready
//   rsp       out        rsp_valid rsp_ready rsp_data       rsp_valid && rsp_ready
//   csr       in         csr_we csr_index csr_wdata         csr_we
//
// One item per cycle unless rsp stalls; each item gives one result via both registers.
// The session update runs between the input register and the result register.
// A stalled result holds the result register; the input register keeps taking
// a transfer while it can drain in the same cycle.
// Synchronous reset clears the session state and loads the default timings.
`include "retry_handshake_timeout_controller_unit_macros.svh"

module retry_handshake_timeout_controller_unit
   import rhtc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    step;
   cfg_type cfg;
   rsp_type result;

   rhtc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rhtc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign step         = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || step;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `RHTC_ASSERT_NEXT(a_hold_pending, in_valid_ff && !step, in_valid_ff, "pending item lost")
   `RHTC_ASSERT_NEXT(a_step_result, step, out_valid_ff, "processed item left no result")
   `RHTC_ASSERT_IMPLIES(a_mode_busy, out_valid_ff && out_data_ff.mode_now != '0, out_data_ff.busy_res, "mode shown while idle")
   `RHTC_ASSERT_IMPLIES(a_one_action, out_valid_ff, $onehot0({out_data_ff.do_hard_reset, out_data_ff.do_refresh}), "hard reset and refresh together")
   `RHTC_ASSERT_IMPLIES(a_action_tick, out_valid_ff && (out_data_ff.do_attempt || out_data_ff.do_hard_reset || out_data_ff.do_refresh), out_data_ff.event_res == EV_NONE, "action with event")

endmodule
